/* rtl/core/mvtg_pkg.sv */
// Shared types, constants and tables of the multi-voice tone generator.
package mvtg_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PH_GO,
        ST_PH_W,
        ST_WAVE,
        ST_NZ_GO,
        ST_NZ_W,
        ST_TRI,
        ST_Z2_GO,
        ST_Z2_W,
        ST_Y1_GO,
        ST_Y1_W,
        ST_Y2_GO,
        ST_Y2_W,
        ST_Y3_GO,
        ST_Y3_W,
        ST_MX_GO,
        ST_MX_W,
        ST_SC_GO,
        ST_SC_W,
        ST_DIV,
        ST_EMIT
    } mvtg_state_t;

    typedef enum logic [1:0] {
        WFM_SINE   = 2'd0,
        WFM_SQUARE = 2'd1,
        WFM_TRI    = 2'd2,
        WFM_NOISE  = 2'd3
    } mvtg_wave_t;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [35:0] MIX_DIVISOR = 36'd520200;
    localparam int          DIV_STEPS = 17;
    localparam logic [15:0] POLY_A = 16'd51472;
    localparam logic [15:0] POLY_B = 16'd21024;
    localparam logic [15:0] POLY_C = 16'd2320;
    localparam logic signed [29:0] SUM_MAX = 30'sd134217727;
    localparam logic signed [29:0] SUM_MIN = -30'sd134217728;

    // Phase steps of the top octave, round(f * 2^32 / 22050).
    function automatic logic [31:0] top_step(input logic [3:0] note);
        logic [31:0] s;
        begin
            case (note)
                4'd0:    s = 32'd407681904;
                4'd1:    s = 32'd431923931;
                4'd2:    s = 32'd457607465;
                4'd3:    s = 32'd484818220;
                4'd4:    s = 32'd513647012;
                4'd5:    s = 32'd544190053;
                4'd6:    s = 32'd576549277;
                4'd7:    s = 32'd610832681;
                4'd8:    s = 32'd647154683;
                4'd9:    s = 32'd685636503;
                4'd10:   s = 32'd726406571;
                4'd11:   s = 32'd769600953;
                default: s = 32'd0;
            endcase
            return s;
        end
    endfunction

    // Rounding right shift of the top-octave step down to the given octave.
    function automatic logic [31:0] step_of(input logic [2:0] octave, input logic [3:0] note);
        logic [32:0] top;
        logic [32:0] r;
        begin
            top = {1'b0, top_step(note)};
            case (octave)
                3'd0:    r = (top + 33'd32) >> 6;
                3'd1:    r = (top + 33'd16) >> 5;
                3'd2:    r = (top + 33'd8) >> 4;
                3'd3:    r = (top + 33'd4) >> 3;
                3'd4:    r = (top + 33'd2) >> 2;
                3'd5:    r = (top + 33'd1) >> 1;
                default: r = top;
            endcase
            return r[31:0];
        end
    endfunction

    // Triangle wave in Q1.15 at a 32-bit phase.
    function automatic logic signed [16:0] triangle_of(input logic [31:0] p);
        logic [31:0]        u;
        logic signed [18:0] w;
        logic signed [18:0] d;
        begin
            u = p + 32'h4000_0000;
            w = $signed({2'b00, u[31:15]}) - 19'sd65536;
            if (w < 0) begin
                w = -w;
            end
            d = w - 19'sd32768;
            if (d > 19'sd32767) begin
                d = 19'sd32767;
            end
            return d[16:0];
        end
    endfunction

endpackage

/* rtl/core/mvtg_mul.sv */
// Bit-serial shift-and-add multiplier shared by all products of the generator.
module mvtg_mul
    import mvtg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a_in,
    input  logic [MUL_B_W-1:0] b_in,
    output logic               done,
    output logic [MUL_A_W-1:0] product
);

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_A_W-1:0] acc_reg;
    logic               busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && (b_reg == '0)) begin
            busy_reg <= 1'b0;
        end
    end

    // One multiplier bit per cycle; stop as soon as no set bits remain.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
        end else if (busy_reg && (b_reg != '0)) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

endmodule

/* rtl/core/multi_voice_tone_generator.sv */
// Top level of the multi-voice tone generator: voice sequencer, mixer and scaler.
//
// Voices of one audio sample arrive on s_* one request at a time; the request
// with s_last_voice high closes the sample and one mixed sample leaves on m_*.
// cfg_* writes the master volume (reset 255); write it only while idle.
// Each voice is worked through a bit-serial multiplier, one multiplier bit a
// cycle. From its accept a voice holds the block for its products: sine or
// square use the phase product, four polynomial products and the volume
// product, triangle uses the phase and volume products, and noise adds a
// noise product to those of triangle; a silent or surplus voice does no work.
// A closing voice adds the master product, a 17-step restoring division, and
// a final state that loads the output register.
// s_ready is high only while no voice is in work. The output register holds
// a finished sample while the next sample's voices are taken; if it is still
// full when the next sample closes, the block waits for m_ready.
// Reset (aresetn low, synchronous) clears the sample counter, the running
// sum, the voice count, the output valid and loads the noise seed.
module multi_voice_tone_generator
    import mvtg_pkg::*;
#(
    parameter int COUNTER_BITS   = 24,
    parameter int MAX_VOICES     = 8,
    parameter int SINE_ROM_DEPTH = 256
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_master_volume,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_octave,
    input  logic [3:0]         s_note,
    input  logic               s_active,
    input  logic [1:0]         s_wave,
    input  logic [7:0]         s_volume,
    input  logic               s_last_voice,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_out
);

    localparam int AW = $clog2(SINE_ROM_DEPTH);
    localparam int CW = $clog2(MAX_VOICES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VOICES);

    mvtg_state_t state_reg, state_next;

    logic [COUNTER_BITS-1:0] counter_reg;
    logic signed [27:0]      sum_reg;
    logic [15:0]             lfsr_reg;
    logic [7:0]              master_reg;
    logic [CW-1:0]           count_reg;
    logic                    m_valid_reg;
    logic signed [15:0]      m_data_reg;

    logic [31:0]        step_reg;
    logic [31:0]        phase_reg;
    logic [1:0]         wave_reg;
    logic [7:0]         volume_reg;
    logic               last_reg;
    logic [15:0]        z_reg;
    logic [15:0]        z2_reg;
    logic [15:0]        y_reg;
    logic [1:0]         quad_reg;
    logic signed [16:0] d_reg;
    logic [35:0]        rem_reg;
    logic [16:0]        quo_reg;
    logic [4:0]         bit_reg;

    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_A_W-1:0] mul_p;

    logic               s_fire;
    logic               voice_on;
    logic               out_free;
    logic [AW-1:0]      sin_idx;
    logic [15:0]        sin_t;
    logic [15:0]        z_raw;
    logic [16:0]        d_abs;
    logic [28:0]        sum_neg;
    logic [27:0]        sum_abs;
    logic [29:0]        mix_term;
    logic signed [29:0] mix_sum;
    logic [35:0]        div_sub;
    logic [16:0]        y_clamp;
    logic [16:0]        q_sat;
    logic [15:0]        lfsr_step;

    assign s_fire   = s_valid && s_ready;
    assign voice_on = (count_reg < CNT_MAX) && s_active && (s_note < 4'd12);
    assign out_free = !m_valid_reg || m_ready;

    // Mirror the angle in the odd quadrants.
    assign sin_idx = phase_reg[31 -: AW];
    assign sin_t   = 16'(sin_idx) << (16 - AW);
    assign z_raw   = sin_t[14] ? 16'h8000 - {1'b0, sin_t[13:0], 1'b0}
                               : {1'b0, sin_t[13:0], 1'b0};

    assign d_abs    = d_reg[16] ? 17'(-d_reg) : 17'(d_reg);
    assign sum_neg  = -{sum_reg[27], sum_reg};
    assign sum_abs  = sum_reg[27] ? sum_neg[27:0] : sum_reg;
    assign mix_term = d_reg[16] ? -30'(mul_p[23:0]) : 30'(mul_p[23:0]);
    assign mix_sum  = 30'(sum_reg) + $signed(mix_term);
    assign div_sub  = MIX_DIVISOR << bit_reg;
    assign y_clamp  = (mul_p[31:15] > 17'd32767) ? 17'd32767 : mul_p[31:15];
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

    mvtg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (voice_on) begin
                        state_next = ST_PH_GO;
                    end else if (s_last_voice) begin
                        state_next = ST_SC_GO;
                    end
                end
            end
            ST_PH_GO: state_next = ST_PH_W;
            ST_PH_W:  if (mul_done) state_next = ST_WAVE;
            ST_WAVE: begin
                case (wave_reg)
                    WFM_NOISE: state_next = ST_NZ_GO;
                    WFM_TRI:   state_next = ST_TRI;
                    default:   state_next = ST_Z2_GO;
                endcase
            end
            ST_NZ_GO: state_next = ST_NZ_W;
            ST_NZ_W:  if (mul_done) state_next = ST_TRI;
            ST_TRI:   state_next = ST_MX_GO;
            ST_Z2_GO: state_next = ST_Z2_W;
            ST_Z2_W:  if (mul_done) state_next = ST_Y1_GO;
            ST_Y1_GO: state_next = ST_Y1_W;
            ST_Y1_W:  if (mul_done) state_next = ST_Y2_GO;
            ST_Y2_GO: state_next = ST_Y2_W;
            ST_Y2_W:  if (mul_done) state_next = ST_Y3_GO;
            ST_Y3_GO: state_next = ST_Y3_W;
            ST_Y3_W:  if (mul_done) state_next = ST_MX_GO;
            ST_MX_GO: state_next = ST_MX_W;
            ST_MX_W: begin
                if (mul_done) begin
                    state_next = last_reg ? ST_SC_GO : ST_IDLE;
                end
            end
            ST_SC_GO: state_next = ST_SC_W;
            ST_SC_W:  if (mul_done) state_next = ST_DIV;
            ST_DIV:   if (bit_reg == 5'd0) state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Multiplier requests.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_PH_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(step_reg);
                mul_b     = MUL_B_W'(counter_reg);
            end
            ST_NZ_GO: begin
                // Use the advanced noise word.
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(step_reg);
                mul_b     = MUL_B_W'(lfsr_step);
            end
            ST_Z2_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(z_reg);
                mul_b     = MUL_B_W'(z_reg);
            end
            ST_Y1_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(z2_reg);
                mul_b     = MUL_B_W'(POLY_C);
            end
            ST_Y2_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(z2_reg);
                mul_b     = MUL_B_W'(y_reg);
            end
            ST_Y3_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(z_reg);
                mul_b     = MUL_B_W'(y_reg);
            end
            ST_MX_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(d_abs);
                mul_b     = MUL_B_W'(volume_reg);
            end
            ST_SC_GO: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(sum_abs);
                mul_b     = MUL_B_W'(master_reg);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign q_sat = sum_reg[27] ? ((quo_reg > 17'd32768) ? 17'd32768 : quo_reg)
                               : ((quo_reg > 17'd32767) ? 17'd32767 : quo_reg);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            counter_reg <= '0;
            sum_reg     <= '0;
            lfsr_reg    <= LFSR_SEED;
            master_reg  <= 8'd255;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                master_reg <= cfg_master_volume;
            end
            if ((state_reg == ST_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_fire && (count_reg != CNT_MAX)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ST_NZ_GO) begin
                lfsr_reg <= lfsr_step;
            end
            if ((state_reg == ST_MX_W) && mul_done) begin
                if (mix_sum > SUM_MAX) begin
                    sum_reg <= SUM_MAX[27:0];
                end else if (mix_sum < SUM_MIN) begin
                    sum_reg <= SUM_MIN[27:0];
                end else begin
                    sum_reg <= mix_sum[27:0];
                end
            end
            if ((state_reg == ST_EMIT) && out_free) begin
                counter_reg <= counter_reg + 1'b1;
                sum_reg     <= '0;
                count_reg   <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    step_reg   <= step_of(s_octave, s_note);
                    wave_reg   <= s_wave;
                    volume_reg <= s_volume;
                    last_reg   <= s_last_voice;
                end
            end
            ST_PH_W: begin
                if (mul_done) begin
                    phase_reg <= mul_p[31:0];
                end
            end
            ST_WAVE: begin
                z_reg    <= z_raw;
                quad_reg <= sin_t[15:14];
            end
            ST_NZ_W: begin
                if (mul_done) begin
                    phase_reg <= phase_reg + mul_p[40:9] - (step_reg << 6);
                end
            end
            ST_TRI: begin
                d_reg <= triangle_of(phase_reg);
            end
            ST_Z2_W: begin
                if (mul_done) begin
                    z2_reg <= mul_p[30:15];
                end
            end
            ST_Y1_W: begin
                if (mul_done) begin
                    y_reg <= POLY_B - mul_p[30:15];
                end
            end
            ST_Y2_W: begin
                if (mul_done) begin
                    y_reg <= POLY_A - mul_p[30:15];
                end
            end
            ST_Y3_W: begin
                if (mul_done) begin
                    if (wave_reg == WFM_SINE) begin
                        d_reg <= quad_reg[1] ? -$signed(y_clamp) : $signed(y_clamp);
                    end else begin
                        // Square follows the sign of the sine; zero counts as positive.
                        d_reg <= (!quad_reg[1] || (y_clamp == 17'd0)) ? 17'sd32767
                                                                      : -17'sd32768;
                    end
                end
            end
            ST_SC_W: begin
                if (mul_done) begin
                    rem_reg <= mul_p[35:0];
                    quo_reg <= '0;
                    bit_reg <= 5'(DIV_STEPS - 1);
                end
            end
            ST_DIV: begin
                if (rem_reg >= div_sub) begin
                    rem_reg          <= rem_reg - div_sub;
                    quo_reg[bit_reg] <= 1'b1;
                end
                if (bit_reg != 5'd0) begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_data_reg <= sum_reg[27] ? -$signed(q_sat[15:0]) : $signed(q_sat[15:0]);
                end
            end
            default: begin
                bit_reg <= bit_reg;
            end
        endcase
    end

endmodule
